// ----- rtl/mse_pkg.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute package
// Opcode and function codes, status codes and the execute result record
// shared by the execute unit and the top level.
// ----------------------------------------------------------------------------
package mse_pkg;

  // Default data memory depth in words.
  localparam int DataWordsDef = 1024;

  // Reset value of the stack pointer, register 29.
  localparam logic [31:0] SpReset = 32'h0000_4000;
  localparam logic [4:0]  SpIndex = 5'd29;
  localparam logic [4:0]  RaIndex = 5'd31;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // Function codes of the SPECIAL opcode.
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_MOVZ = 6'h0A;
  localparam logic [5:0] FN_MOVN = 6'h0B;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNKNOWN    = 2'd1,
    ST_MISALIGNED = 2'd2
  } status_t;

  // Everything the execute unit decides for one instruction.
  typedef struct packed {
    status_t     status;
    logic        we;
    logic [4:0]  dest;
    logic [31:0] val;
    logic        is_load;
    logic [5:0]  load_op;
    logic [1:0]  lane;
    logic        mem_write;
    logic [31:0] maddr;
    logic [31:0] mdata;
    logic [3:0]  mask;
    logic        new_pend;
    logic [31:0] new_target;
  } exec_t;

endpackage

// ----- rtl/mse_exec.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute unit
// Decodes one instruction and works out its register result, store lanes,
// effective address and branch redirect from the two operand values.
// ----------------------------------------------------------------------------
module mse_exec (
  input  logic [31:0]   instr,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  input  logic [31:0]   pc,
  output mse_pkg::exec_t res
);

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [31:0] ea;
  logic [31:0] pc4;

  assign op   = instr[31:26];
  assign rs   = instr[25:21];
  assign rt   = instr[20:16];
  assign rd   = instr[15:11];
  assign sh   = instr[10:6];
  assign fn   = instr[5:0];
  assign imm  = {16'h0000, instr[15:0]};
  assign simm = {{16{instr[15]}}, instr[15:0]};
  assign ea   = a + simm;
  assign pc4  = pc + 32'd4;

  // Decode and execute.
  always_comb begin
    logic we;
    logic [4:0] dest;
    logic [31:0] val;
    we  = 1'b0;
    dest = rt;
    val = 32'h0;
    res = '0;
    res.status  = mse_pkg::ST_OK;
    res.load_op = op;
    res.lane    = ea[1:0];
    if (op == mse_pkg::OP_SPECIAL) begin
      dest = rd;
      we   = 1'b1;
      unique case (fn)
        mse_pkg::FN_ADD:  val = a + b;
        mse_pkg::FN_SUB,
        mse_pkg::FN_SUBU: val = a - b;
        mse_pkg::FN_AND:  val = a & b;
        mse_pkg::FN_OR:   val = a | b;
        mse_pkg::FN_XOR:  val = a ^ b;
        mse_pkg::FN_NOR:  val = ~(a | b);
        mse_pkg::FN_SLT:  val = {31'h0, $signed(a) < $signed(b)};
        mse_pkg::FN_MOVZ: begin
          val = a;
          we  = (b == 32'h0);
        end
        mse_pkg::FN_MOVN: begin
          val = a;
          we  = (b != 32'h0);
        end
        mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_SRA: begin
          if (rs != 5'd0) begin
            res.status = mse_pkg::ST_UNKNOWN;
            we = 1'b0;
          end else if (fn == mse_pkg::FN_SLL) begin
            val = b << sh;
          end else if (fn == mse_pkg::FN_SRL) begin
            val = b >> sh;
          end else begin
            val = $unsigned($signed(b) >>> sh);
          end
        end
        default: begin
          res.status = mse_pkg::ST_UNKNOWN;
          we = 1'b0;
        end
      endcase
    end else begin
      unique case (op)
        mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin
          val = ea;
          we  = 1'b1;
        end
        mse_pkg::OP_ANDI: begin
          val = a & imm;
          we  = 1'b1;
        end
        mse_pkg::OP_ORI: begin
          val = a | imm;
          we  = 1'b1;
        end
        mse_pkg::OP_XORI: begin
          val = a ^ imm;
          we  = 1'b1;
        end
        mse_pkg::OP_LUI: begin
          if (rs != 5'd0) begin
            res.status = mse_pkg::ST_UNKNOWN;
          end else begin
            val = {instr[15:0], 16'h0000};
            we  = 1'b1;
          end
        end
        mse_pkg::OP_SLTI: begin
          val = {31'h0, $signed(a) < $signed(simm)};
          we  = 1'b1;
        end
        mse_pkg::OP_SLTIU: begin
          val = {31'h0, a < simm};
          we  = 1'b1;
        end
        mse_pkg::OP_LB, mse_pkg::OP_LBU, mse_pkg::OP_LH, mse_pkg::OP_LHU,
        mse_pkg::OP_LW: begin
          res.maddr = ea;
          if (((op == mse_pkg::OP_LH || op == mse_pkg::OP_LHU) && ea[0]) ||
              (op == mse_pkg::OP_LW && ea[1:0] != 2'b00)) begin
            res.status = mse_pkg::ST_MISALIGNED;
          end else begin
            res.is_load = 1'b1;
            we = 1'b1;
          end
        end
        mse_pkg::OP_SB, mse_pkg::OP_SH, mse_pkg::OP_SW: begin
          res.maddr = ea;
          if ((op == mse_pkg::OP_SH && ea[0]) ||
              (op == mse_pkg::OP_SW && ea[1:0] != 2'b00)) begin
            res.status = mse_pkg::ST_MISALIGNED;
          end else begin
            res.mem_write = 1'b1;
            if (op == mse_pkg::OP_SB) begin
              res.mask  = 4'b0001 << ea[1:0];
              res.mdata = {24'h0, b[7:0]} << {ea[1:0], 3'b000};
            end else if (op == mse_pkg::OP_SH) begin
              res.mask  = 4'b0011 << ea[1:0];
              res.mdata = {16'h0, b[15:0]} << {ea[1:0], 3'b000};
            end else begin
              res.mask  = 4'b1111;
              res.mdata = b;
            end
          end
        end
        mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
          if ((op == mse_pkg::OP_BEQ) == (a == b)) begin
            res.new_pend   = 1'b1;
            res.new_target = pc4 + {simm[29:0], 2'b00};
          end
        end
        mse_pkg::OP_J, mse_pkg::OP_JAL: begin
          res.new_pend   = 1'b1;
          res.new_target = {pc4[31:28], instr[25:0], 2'b00};
          if (op == mse_pkg::OP_JAL) begin
            dest = mse_pkg::RaIndex;
            val  = pc + 32'd8;
            we   = 1'b1;
          end
        end
        default: res.status = mse_pkg::ST_UNKNOWN;
      endcase
    end
    // Writes to register zero are dropped and reported as no write.
    if (!we || dest == 5'd0) begin
      res.we      = 1'b0;
      res.dest    = 5'd0;
      res.val     = 32'h0;
      res.is_load = 1'b0;
    end else begin
      res.we   = 1'b1;
      res.dest = dest;
      res.val  = val;
    end
  end

endmodule

// ----- rtl/mips_subset_execute.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute
// Executes one MIPS instruction word per cycle, unless stalled, against an
// internal register file, data memory and PC, with one branch delay slot.
// ----------------------------------------------------------------------------
// One instruction word is accepted per clock cycle unless the result side
// stalls. Each word passes through an input register, an execute stage that
// reads the register file and issues the data memory access, a completion
// stage that shapes load data and writes the register file, and an output
// register. The single data memory port (one read and one byte-lane write
// per cycle) sets that rate. Loads feed a following instruction through a
// forwarding path, so there is no stall between dependent instructions.
// After reset the data memory is swept to zero at one word per cycle, and
// no word is accepted until the sweep is done. Each instruction reports
// its next fetch address, a status and any register or memory write it made.
module mips_subset_execute #(
  parameter int DATA_WORDS = mse_pkg::DataWordsDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // [31:0] instr_word
  output logic         m_tvalid,
  input  logic         m_tready,
  // [31:0] next_pc, [33:32] status, [34] reg_write, [39:35] reg_index,
  // [71:40] reg_value, [72] mem_write, [104:73] mem_addr,
  // [136:105] mem_data, [140:137] byte_mask, [143:141] zero
  output logic [143:0] m_tdata
);

  localparam int AW   = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam bit POW2 = ((DATA_WORDS & (DATA_WORDS - 1)) == 0);
  localparam int SH   = 30 + AW;
  localparam longint RECIP = ((longint'(1) << SH) + longint'(DATA_WORDS) - 1) /
                             longint'(DATA_WORDS);

  logic        adv;
  logic        clearing;
  logic [AW-1:0] clr_cnt;

  logic        s1_valid;
  logic [31:0] s1_instr;

  logic [31:0] pc;
  logic        pend;
  logic [31:0] target;
  logic [31:0] pc_next;

  logic [31:0] rf [32];
  logic [31:0] mem [DATA_WORDS];
  logic [31:0] rdata;

  logic [31:0] op_a;
  logic [31:0] op_b;
  mse_pkg::exec_t ex;

  logic        s2_valid;
  mse_pkg::exec_t s2;
  logic [31:0] s2_pc;
  logic [31:0] s2_fin;
  logic [31:0] lword;

  logic [AW-1:0] widx;

  logic        o_valid;
  logic [31:0] o_pc;
  logic [1:0]  o_status;
  logic        o_we;
  logic [4:0]  o_dest;
  logic [31:0] o_val;
  logic        o_mw;
  logic [31:0] o_maddr;
  logic [31:0] o_mdata;
  logic [3:0]  o_mask;

  // The whole pipeline moves when the output word is free or being taken.
  assign adv      = !o_valid || m_tready;
  assign s_tready = adv && !clearing;

  // Clearing sweep of the data memory after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == AW'(DATA_WORDS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid && s_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_instr <= s_tdata;
    end
  end

  // Operand reads, forwarding the completing instruction's result.
  always_comb begin
    if (s1_instr[25:21] == 5'd0) begin
      op_a = 32'h0;
    end else if (s2_valid && s2.we && s2.dest == s1_instr[25:21]) begin
      op_a = s2_fin;
    end else begin
      op_a = rf[s1_instr[25:21]];
    end
    if (s1_instr[20:16] == 5'd0) begin
      op_b = 32'h0;
    end else if (s2_valid && s2.we && s2.dest == s1_instr[20:16]) begin
      op_b = s2_fin;
    end else begin
      op_b = rf[s1_instr[20:16]];
    end
  end

  mse_exec u_exec (
    .instr (s1_instr),
    .a     (op_a),
    .b     (op_b),
    .pc    (pc),
    .res   (ex)
  );

  // Fetch address after this instruction, honouring a pending redirect.
  assign pc_next = pend ? target : pc + 32'd4;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= 32'h0;
      pend   <= 1'b0;
      target <= 32'h0;
    end else if (adv && s1_valid) begin
      pc   <= pc_next;
      pend <= ex.new_pend;
      if (ex.new_pend) begin
        target <= ex.new_target;
      end
    end
  end

  // Word index of the effective address, wrapped to the memory depth.
  generate
    if (POW2) begin : g_mask
      assign widx = ex.maddr[AW+1:2];
    end else begin : g_recip
      logic [29:0] wa;
      logic [63:0] prod;
      logic [29:0] quot;
      logic [63:0] back;
      assign wa   = ex.maddr[31:2];
      assign prod = {34'h0, wa} * 64'(RECIP);
      assign quot = 30'(prod >> SH);
      assign back = {34'h0, quot} * 64'(DATA_WORDS);
      assign widx = AW'({34'h0, wa} - back);
    end
  endgenerate

  // Data memory: at most one byte-lane write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= 32'h0;
    end else if (adv && s1_valid && ex.mem_write) begin
      for (int k = 0; k < 4; k++) begin
        if (ex.mask[k]) begin
          mem[widx][8*k +: 8] <= ex.mdata[8*k +: 8];
        end
      end
    end
    if (adv) begin
      rdata <= mem[widx];
    end
  end

  // Completion stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2    <= ex;
      s2_pc <= pc_next;
    end
  end

  // Load data shaping from the addressed lanes.
  assign lword = rdata >> {s2.lane, 3'b000};

  always_comb begin
    if (!s2.is_load) begin
      s2_fin = s2.val;
    end else begin
      unique case (s2.load_op)
        mse_pkg::OP_LB:  s2_fin = {{24{lword[7]}}, lword[7:0]};
        mse_pkg::OP_LBU: s2_fin = {24'h0, lword[7:0]};
        mse_pkg::OP_LH:  s2_fin = {{16{lword[15]}}, lword[15:0]};
        mse_pkg::OP_LHU: s2_fin = {16'h0, lword[15:0]};
        default:         s2_fin = lword;
      endcase
    end
  end

  // Register file write at completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 32; i++) begin
        rf[i] <= (5'(i) == mse_pkg::SpIndex) ? mse_pkg::SpReset : 32'h0;
      end
    end else if (adv && s2_valid && s2.we) begin
      rf[s2.dest] <= s2_fin;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_pc     <= s2_pc;
      o_status <= s2.status;
      o_we     <= s2.we;
      o_dest   <= s2.dest;
      o_val    <= s2_fin;
      o_mw     <= s2.mem_write;
      o_maddr  <= s2.maddr;
      o_mdata  <= s2.mdata;
      o_mask   <= s2.mask;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {3'b000, o_mask, o_mdata, o_maddr, o_mw, o_val, o_dest, o_we,
                     o_status, o_pc};

endmodule

// ----- rtl/mse_checker.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute port checker
// Watches the top level's ports and checks the result words it shows.
// ----------------------------------------------------------------------------
module mse_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata
);

  // A stalled result word stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word dropped while stalled");

  // No input is taken right after reset, when the memory clearing starts.
  a_clear: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("input accepted during memory clearing");

  // Status is never the unused code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[33:32] != 2'd3)
    else $error("invalid status code");

  // No register write means index and value are zero.
  a_regw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[34] |-> m_tdata[39:35] == 5'd0 && m_tdata[71:40] == 32'h0)
    else $error("register fields set without a write");

  // No store means no byte lanes and no store data.
  a_memw: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[72] |-> m_tdata[140:137] == 4'h0 && m_tdata[136:105] == 32'h0)
    else $error("store fields set without a store");

endmodule

bind mips_subset_execute mse_checker u_mse_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// MIPS subset execute testbench
// Drives instruction words into the execute unit, predicts every result word
// from a behavioural copy of the register file, data memory and program
// counter, and compares each result field by field with random idling on
// both sides.
// ----------------------------------------------------------------------------
module tb;

  localparam int WatchLimit = 20000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [31:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [143:0] m_tdata;

  // Fields listed from the highest bit down, matching the result word.
  typedef struct packed {
    logic [3:0]       byte_mask;
    logic [31:0]      mem_data;
    logic [31:0]      mem_addr;
    logic             mem_write;
    logic [31:0]      reg_value;
    logic [4:0]       reg_index;
    logic             reg_write;
    mse_pkg::status_t status;
    logic [31:0]      next_pc;
  } outcome_t;

  // Model state of the core.
  logic [31:0] gpr [32];
  logic [31:0] dmem [mse_pkg::DataWordsDef];
  logic [31:0] pc_q;
  logic        pend_q;
  logic [31:0] target_q;

  outcome_t pending_outcomes [$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  int       out_wait = 0;

  mips_subset_execute dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // Number of idle cycles before a word, often none.
  function automatic int draw_gap();
    int gap;
    gap = $urandom_range(0, 14);
    if ($urandom_range(0, 3) == 0) gap = 0;
    return gap;
  endfunction

  // Predicts the result of one instruction and updates the model state.
  function automatic outcome_t execute_instr(logic [31:0] w);
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] simm;
    logic [31:0] imm;
    logic [31:0] ea;
    logic [31:0] word;
    logic [31:0] bits;
    logic [1:0]  lane;
    logic        wr;
    logic        npend;
    logic [31:0] ntarget;
    int          idx;
    outcome_t    r;
    op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
    sh = w[10:6]; fn = w[5:0];
    imm = {16'h0, w[15:0]};
    simm = {{16{w[15]}}, w[15:0]};
    a = gpr[rs]; b = gpr[rt];
    ea = a + simm; lane = ea[1:0];
    r = '0;
    r.next_pc = pend_q ? target_q : pc_q + 32'd4;
    r.status = mse_pkg::ST_OK;
    wr = 1'b0; npend = 1'b0; ntarget = '0;
    idx = int'(ea[31:2]) % mse_pkg::DataWordsDef;
    if (op == mse_pkg::OP_SPECIAL) begin
      r.reg_index = rd;
      wr = 1'b1;
      case (fn)
        mse_pkg::FN_ADD: r.reg_value = a + b;
        mse_pkg::FN_SUB, mse_pkg::FN_SUBU: r.reg_value = a - b;
        mse_pkg::FN_AND: r.reg_value = a & b;
        mse_pkg::FN_OR: r.reg_value = a | b;
        mse_pkg::FN_XOR: r.reg_value = a ^ b;
        mse_pkg::FN_NOR: r.reg_value = ~(a | b);
        mse_pkg::FN_SLT: r.reg_value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        mse_pkg::FN_MOVZ: begin r.reg_value = a; wr = (b == 0); end
        mse_pkg::FN_MOVN: begin r.reg_value = a; wr = (b != 0); end
        mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_SRA: begin
          if (rs != 0) begin
            r.status = mse_pkg::ST_UNKNOWN; wr = 1'b0;
          end else if (fn == mse_pkg::FN_SLL) begin
            r.reg_value = b << sh;
          end else if (fn == mse_pkg::FN_SRL) begin
            r.reg_value = b >> sh;
          end else begin
            r.reg_value = $unsigned($signed(b) >>> sh);
          end
        end
        default: begin r.status = mse_pkg::ST_UNKNOWN; wr = 1'b0; end
      endcase
    end else begin
      r.reg_index = rt;
      case (op)
        mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: begin r.reg_value = a + simm; wr = 1'b1; end
        mse_pkg::OP_ANDI: begin r.reg_value = a & imm; wr = 1'b1; end
        mse_pkg::OP_ORI: begin r.reg_value = a | imm; wr = 1'b1; end
        mse_pkg::OP_XORI: begin r.reg_value = a ^ imm; wr = 1'b1; end
        mse_pkg::OP_LUI: begin
          if (rs != 0) r.status = mse_pkg::ST_UNKNOWN;
          else begin r.reg_value = {w[15:0], 16'h0}; wr = 1'b1; end
        end
        mse_pkg::OP_SLTI: begin
          r.reg_value = ($signed(a) < $signed(simm)) ? 32'd1 : 32'd0; wr = 1'b1;
        end
        mse_pkg::OP_SLTIU: begin r.reg_value = (a < simm) ? 32'd1 : 32'd0; wr = 1'b1; end
        mse_pkg::OP_LB, mse_pkg::OP_LBU, mse_pkg::OP_LH, mse_pkg::OP_LHU,
        mse_pkg::OP_LW: begin
          r.mem_addr = ea;
          if (((op == mse_pkg::OP_LH || op == mse_pkg::OP_LHU) && ea[0]) ||
              (op == mse_pkg::OP_LW && lane != 0)) begin
            r.status = mse_pkg::ST_MISALIGNED;
          end else begin
            word = dmem[idx] >> (8 * lane);
            case (op)
              mse_pkg::OP_LB: r.reg_value = {{24{word[7]}}, word[7:0]};
              mse_pkg::OP_LBU: r.reg_value = {24'h0, word[7:0]};
              mse_pkg::OP_LH: r.reg_value = {{16{word[15]}}, word[15:0]};
              mse_pkg::OP_LHU: r.reg_value = {16'h0, word[15:0]};
              default: r.reg_value = word;
            endcase
            wr = 1'b1;
          end
        end
        mse_pkg::OP_SB, mse_pkg::OP_SH, mse_pkg::OP_SW: begin
          r.mem_addr = ea;
          if ((op == mse_pkg::OP_SH && ea[0]) || (op == mse_pkg::OP_SW && lane != 0)) begin
            r.status = mse_pkg::ST_MISALIGNED;
          end else begin
            if (op == mse_pkg::OP_SB) begin
              r.byte_mask = 4'b0001 << lane;
              r.mem_data = {24'h0, b[7:0]} << (8 * lane);
            end else if (op == mse_pkg::OP_SH) begin
              r.byte_mask = 4'b0011 << lane;
              r.mem_data = {16'h0, b[15:0]} << (8 * lane);
            end else begin
              r.byte_mask = 4'hF;
              r.mem_data = b;
            end
            bits = '0;
            for (int k = 0; k < 4; k++)
              if (r.byte_mask[k]) bits[8*k +: 8] = 8'hFF;
            dmem[idx] = (dmem[idx] & ~bits) | r.mem_data;
            r.mem_write = 1'b1;
          end
        end
        mse_pkg::OP_BEQ, mse_pkg::OP_BNE: begin
          if ((op == mse_pkg::OP_BEQ) == (a == b)) begin
            npend = 1'b1;
            ntarget = pc_q + 32'd4 + (simm << 2);
          end
        end
        mse_pkg::OP_J, mse_pkg::OP_JAL: begin
          npend = 1'b1;
          ntarget = ((pc_q + 32'd4) & 32'hF000_0000) | {4'h0, w[25:0], 2'b00};
          if (op == mse_pkg::OP_JAL) begin
            r.reg_index = mse_pkg::RaIndex; r.reg_value = pc_q + 32'd8; wr = 1'b1;
          end
        end
        default: r.status = mse_pkg::ST_UNKNOWN;
      endcase
    end
    if (!wr || r.reg_index == 0) begin
      r.reg_write = 1'b0; r.reg_index = '0; r.reg_value = '0;
    end else begin
      r.reg_write = 1'b1;
      gpr[r.reg_index] = r.reg_value;
    end
    pend_q = npend;
    if (npend) target_q = ntarget;
    pc_q = r.next_pc;
    return r;
  endfunction

  // Sends one instruction word after a random gap and records its outcome.
  task automatic send_instr(logic [31:0] w);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_outcomes.push_back(execute_instr(w));
  endtask

  task automatic release_bus();
    s_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] r_type(logic [4:0] rs, logic [4:0] rt,
                                         logic [4:0] rd, logic [4:0] sh,
                                         logic [5:0] fn);
    return {mse_pkg::OP_SPECIAL, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] i_type(logic [5:0] op, logic [4:0] rs,
                                         logic [4:0] rt, logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // Directed: a selection of operations, field extremes and the special cases.
  task automatic test_directed();
    send_instr(i_type(mse_pkg::OP_LUI, 5'd0, 5'd1, 16'hFFFF));
    send_instr(i_type(mse_pkg::OP_ORI, 5'd1, 5'd1, 16'hFFFF));      // r1 = all ones
    send_instr(i_type(mse_pkg::OP_ADDI, 5'd0, 5'd2, 16'h7FFF));
    send_instr(r_type(5'd1, 5'd2, 5'd3, 5'd0, mse_pkg::FN_ADD));
    send_instr(r_type(5'd1, 5'd2, 5'd4, 5'd0, mse_pkg::FN_SUB));
    send_instr(r_type(5'd2, 5'd1, 5'd5, 5'd0, mse_pkg::FN_SLT));
    send_instr(r_type(5'd0, 5'd1, 5'd6, 5'd31, mse_pkg::FN_SRA));
    send_instr(r_type(5'd0, 5'd1, 5'd7, 5'd31, mse_pkg::FN_SRL));
    send_instr(r_type(5'd0, 5'd1, 5'd0, 5'd4, mse_pkg::FN_SLL));    // write to r0 dropped
    send_instr(r_type(5'd3, 5'd1, 5'd8, 5'd4, mse_pkg::FN_SLL));    // rs not zero: unknown
    send_instr(i_type(mse_pkg::OP_LUI, 5'd3, 5'd9, 16'h1234));      // rs not zero: unknown
    send_instr(r_type(5'd1, 5'd0, 5'd9, 5'd0, mse_pkg::FN_MOVN));   // condition false
    send_instr(r_type(5'd1, 5'd0, 5'd9, 5'd0, mse_pkg::FN_MOVZ));
    send_instr(i_type(mse_pkg::OP_SW, 5'd29, 5'd1, 16'hFFFC));
    send_instr(i_type(mse_pkg::OP_SH, 5'd29, 5'd2, 16'h0001));      // misaligned
    send_instr(i_type(mse_pkg::OP_SB, 5'd29, 5'd2, 16'h0003));
    send_instr(i_type(mse_pkg::OP_LB, 5'd29, 5'd10, 16'h0003));
    send_instr(i_type(mse_pkg::OP_LHU, 5'd29, 5'd11, 16'h0002));
    send_instr(i_type(mse_pkg::OP_LW, 5'd29, 5'd12, 16'hFFFE));     // misaligned
    send_instr(i_type(mse_pkg::OP_SLTIU, 5'd0, 5'd13, 16'h8000));
    send_instr(i_type(mse_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));      // taken, far back
    send_instr({mse_pkg::OP_JAL, 26'h3FF_FFFF});                    // branch in delay slot
    send_instr(32'hFFFF_FFFF);                                      // unknown opcode
    send_instr(r_type(5'd1, 5'd1, 5'd14, 5'd0, 6'h3F));             // unknown funct
    send_instr({mse_pkg::OP_J, 26'h0});
    send_instr(i_type(mse_pkg::OP_BNE, 5'd1, 5'd0, 16'h0004));
    send_instr(32'h0);
  endtask

  function automatic logic [31:0] random_instr();
    logic [5:0] ops [21];
    logic [5:0] fns [13];
    logic [31:0] w;
    int pick;
    ops = '{mse_pkg::OP_J, mse_pkg::OP_JAL, mse_pkg::OP_BEQ, mse_pkg::OP_BNE,
            mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU, mse_pkg::OP_SLTI, mse_pkg::OP_SLTIU,
            mse_pkg::OP_ANDI, mse_pkg::OP_ORI, mse_pkg::OP_XORI, mse_pkg::OP_LUI,
            mse_pkg::OP_LB, mse_pkg::OP_LH, mse_pkg::OP_LW, mse_pkg::OP_LBU,
            mse_pkg::OP_LHU, mse_pkg::OP_SB, mse_pkg::OP_SH, mse_pkg::OP_SW,
            mse_pkg::OP_SPECIAL};
    fns = '{mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_SRA, mse_pkg::FN_MOVZ,
            mse_pkg::FN_MOVN, mse_pkg::FN_ADD, mse_pkg::FN_SUB, mse_pkg::FN_SUBU,
            mse_pkg::FN_AND, mse_pkg::FN_OR, mse_pkg::FN_XOR, mse_pkg::FN_NOR,
            mse_pkg::FN_SLT};
    w = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 8) return w;                                // noise
    if (pick < 45) begin
      w[31:26] = mse_pkg::OP_SPECIAL;
      w[5:0] = fns[$urandom_range(0, 12)];
      if ((w[5:0] == mse_pkg::FN_SLL || w[5:0] == mse_pkg::FN_SRL ||
           w[5:0] == mse_pkg::FN_SRA) && $urandom_range(0, 7) != 0)
        w[25:21] = '0;
      return w;
    end
    w[31:26] = ops[$urandom_range(0, 19)];
    if (w[31:26] == mse_pkg::OP_LUI && $urandom_range(0, 7) != 0) w[25:21] = '0;
    // Most memory accesses go through the stack pointer so they hit stored data.
    if (w[31:26] >= mse_pkg::OP_LB && $urandom_range(0, 3) != 0) begin
      w[25:21] = mse_pkg::SpIndex;
      w[15:0] = 16'($urandom_range(0, 63)) - 16'd32;
      if ($urandom_range(0, 3) != 0) w[1:0] = 2'b00;
    end
    if (w[31:26] == mse_pkg::OP_BEQ && $urandom_range(0, 1) == 0) w[20:16] = w[25:21];
    return w;
  endfunction

  // Random instruction stream.
  task automatic test_random();
    for (int i = 0; i < 1500; i++) send_instr(random_instr());
  endtask

  // Result side: a random wait before each word and field checks.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      out_wait <= 0;
    end else if (m_tvalid && m_tready) begin
      outcome_t got;
      outcome_t want;
      int gap;
      got = outcome_t'(m_tdata[140:0]);
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", m_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want || m_tdata[143:141] !== 3'b000) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected %h, got %h", want, got);
        end
      end
      gap = draw_gap();
      out_wait <= gap;
      m_tready <= (gap == 0);
    end else if (out_wait > 0) begin
      out_wait <= out_wait - 1;
      if (out_wait == 1) m_tready <= 1'b1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("FAIL mips_subset_execute");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    gpr[mse_pkg::SpIndex] = mse_pkg::SpReset;
    for (int i = 0; i < mse_pkg::DataWordsDef; i++) dmem[i] = '0;
    pc_q = '0; pend_q = 1'b0; target_q = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    release_bus();
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS mips_subset_execute");
    end else begin
      $display("FAIL mips_subset_execute");
    end
    $finish;
  end
endmodule
